>>> sv/brrg_pkg.sv
// Package for the block-refill random generator: constants and helpers.
`timescale 1ns / 1ps
package brrg_pkg;

  localparam int unsigned POOL_WORDS = 20;
  localparam int unsigned POOL_AW = 5;
  localparam int unsigned GROUPS = 4;
  localparam int unsigned GROUP_WORDS = 5;

  localparam logic [31:0] SPIN_RESET = 32'h9E37_79B9;

  localparam logic [63:0] FIN_MUL1 = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [63:0] FIN_MUL2 = 64'hC4CE_B9FE_1A85_EC53;
  localparam logic [63:0] GOLDEN64 = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [31:0] FIX_K4 = 32'd81016;
  localparam logic [31:0] FIX_K3 = 32'd297442265;
  localparam logic [31:0] FIX_K2 = 32'd5480;
  localparam logic [31:0] FIX_K1 = 32'd19006808;
  localparam logic [3:0]  IDX_MASK = 4'd15;

  localparam logic [4:0] LAST_SEED_WORD = 5'd22;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [63:0] fold33(input logic [63:0] z);
    fold33 = z ^ (z >> 33);
  endfunction

endpackage

>>> sv/block_refill_random_generator_core.sv
// Top level of the block-refill random generator with its refill sequencer.
//
//  channel | ports                     | contents
//  in      | in_tvalid/in_tready       | tuser: action; tdata: seed_low, seed_high
//  out     | out_tvalid/out_tready     | tdata: value
//  cfg     | cfg_we/cfg_wdata          | spin_increment
//
// A draw with words left in the pool passes through accept, pool read and output.
// Refill runs through one adder path; the first draw after a seed runs it twice.
// Seed: 23 finalized words, the 64-bit product built from three 32x32 passes.
// rst_n clears control state, mixing words and pool valid bits; unset pool words read as zero.
// A finished value waits in the output register; the block holds in its last draw step
// only when that register is still full.
`timescale 1ns / 1ps
module block_refill_random_generator_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [0:0]   in_tuser,   // [0] action
  input  logic [127:0] in_tdata,   // [63:0] seed_low, [127:64] seed_high
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // [31:0] value
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);
  import brrg_pkg::*;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_SD_X1   = 5'd1;
  localparam logic [4:0] ST_SD_MUL  = 5'd2;
  localparam logic [4:0] ST_SD_X2   = 5'd3;
  localparam logic [4:0] ST_SD_X3   = 5'd4;
  localparam logic [4:0] ST_RF_RA   = 5'd5;
  localparam logic [4:0] ST_RF_RC   = 5'd6;
  localparam logic [4:0] ST_RF_CNT  = 5'd7;
  localparam logic [4:0] ST_GA      = 5'd8;
  localparam logic [4:0] ST_GB      = 5'd9;
  localparam logic [4:0] ST_EL_RD   = 5'd10;
  localparam logic [4:0] ST_EL_CMP  = 5'd11;
  localparam logic [4:0] ST_EL_ACC  = 5'd12;
  localparam logic [4:0] ST_FIX     = 5'd13;
  localparam logic [4:0] ST_WR      = 5'd14;
  localparam logic [4:0] ST_TAIL    = 5'd15;
  localparam logic [4:0] ST_DR_RD   = 5'd16;
  localparam logic [4:0] ST_DR_OUT  = 5'd17;

  logic [4:0]  state_r, state_nxt;
  logic [31:0] spin_r;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] xor_r, xor_nxt;
  logic [4:0]  rp_r, rp_nxt;
  logic        primed_r, primed_nxt;
  logic [1:0]  rfl_r, rfl_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [1:0]  g_r, g_nxt;
  logic [2:0]  e_r, e_nxt;
  logic [31:0] m_r [GROUPS];
  logic [31:0] m_nxt [GROUPS];
  logic [31:0] grp_r [GROUP_WORDS];
  logic [31:0] grp_nxt [GROUP_WORDS];
  logic [63:0] st_r, st_nxt;
  logic [63:0] mula_r, mula_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        csel_r, csel_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] od_r, od_nxt;

  logic [31:0] pool_mem [POOL_WORDS];
  logic [POOL_WORDS-1:0] pvalid_r;
  logic [31:0] rd_r;
  logic [4:0]  raddr;
  logic        we;
  logic [4:0]  waddr;
  logic [31:0] wdata;

  logic [4:0]  pos;
  logic [3:0]  base3;
  logic [63:0] cmul;
  logic [31:0] mop_a, mop_b;
  logic [63:0] prod;
  logic [63:0] zfin;
  logic [31:0] mg;
  logic [31:0] elem;

  assign pos = {1'b0, g_r, 2'b00} + {3'b000, g_r} + {2'b00, e_r};
  assign base3 = (cnt_r[3:0] + {1'b0, k_r, 1'b0} + {2'b00, k_r}) & IDX_MASK;
  assign cmul = csel_r ? FIN_MUL2 : FIN_MUL1;
  assign mg = m_r[g_r];
  assign zfin = fold33(acc_r);
  assign elem = (rd_r + rotl32(mg, 25)) ^ xor_r;

  always_comb begin
    unique case (ph_r)
      2'd1:    begin mop_a = mula_r[31:0];  mop_b = cmul[63:32]; end
      2'd2:    begin mop_a = mula_r[63:32]; mop_b = cmul[31:0];  end
      default: begin mop_a = mula_r[31:0];  mop_b = cmul[31:0];  end
    endcase
  end
  assign prod = {32'd0, mop_a} * {32'd0, mop_b};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_comb begin
    unique case (state_r)
      ST_RF_RA, ST_RF_RC: raddr = {1'b0, base3};
      ST_EL_RD, ST_EL_CMP: raddr = pos;
      ST_DR_RD, ST_DR_OUT: raddr = rp_r;
      default: raddr = 5'd0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    xor_nxt    = xor_r;
    rp_nxt     = rp_r;
    primed_nxt = primed_r;
    rfl_nxt    = rfl_r;
    k_nxt      = k_r;
    g_nxt      = g_r;
    e_nxt      = e_r;
    m_nxt      = m_r;
    grp_nxt    = grp_r;
    st_nxt     = st_r;
    mula_nxt   = mula_r;
    acc_nxt    = acc_r;
    ph_nxt     = ph_r;
    csel_nxt   = csel_r;
    idx_nxt    = idx_r;
    ov_nxt     = ov_r & ~out_tready;
    od_nxt     = od_r;
    we         = 1'b0;
    waddr      = pos;
    wdata      = grp_r[e_r];

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0]) begin
            st_nxt    = in_tdata[63:0] ^ (in_tdata[127:64] << 1) ^ GOLDEN64;
            idx_nxt   = 5'd0;
            state_nxt = ST_SD_X1;
          end else if (!primed_r) begin
            primed_nxt = 1'b1;
            rfl_nxt    = 2'd2;
            k_nxt      = 2'd0;
            state_nxt  = ST_RF_RA;
          end else if (rp_r >= 5'(POOL_WORDS)) begin
            rfl_nxt   = 2'd1;
            k_nxt     = 2'd0;
            state_nxt = ST_RF_RA;
          end else begin
            state_nxt = ST_DR_RD;
          end
        end
      end
      ST_SD_X1: begin
        mula_nxt  = fold33(st_r);
        csel_nxt  = 1'b0;
        ph_nxt    = 2'd0;
        state_nxt = ST_SD_MUL;
      end
      ST_SD_MUL: begin
        if (ph_r == 2'd0) begin
          acc_nxt = prod;
          ph_nxt  = 2'd1;
        end else begin
          acc_nxt[63:32] = acc_r[63:32] + prod[31:0];
          if (ph_r == 2'd2) begin
            state_nxt = csel_r ? ST_SD_X3 : ST_SD_X2;
          end else begin
            ph_nxt = 2'd2;
          end
        end
      end
      ST_SD_X2: begin
        mula_nxt  = zfin;
        csel_nxt  = 1'b1;
        ph_nxt    = 2'd0;
        state_nxt = ST_SD_MUL;
      end
      ST_SD_X3: begin
        st_nxt = zfin + GOLDEN64;
        waddr  = idx_r;
        wdata  = zfin[63:32];
        if (idx_r < 5'(POOL_WORDS)) begin
          we = 1'b1;
        end else if (idx_r == 5'(POOL_WORDS)) begin
          cnt_nxt = zfin[63:32];
        end else if (idx_r == 5'(POOL_WORDS + 1)) begin
          sum_nxt = zfin[63:32];
        end else begin
          xor_nxt = zfin[63:32];
        end
        if (idx_r == LAST_SEED_WORD) begin
          rp_nxt     = 5'(POOL_WORDS);
          primed_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 5'd1;
          state_nxt = ST_SD_X1;
        end
      end
      ST_RF_RA: begin
        state_nxt = ST_RF_RC;
      end
      ST_RF_RC: begin
        m_nxt[k_r] = rd_r;
        if (k_r == 2'd3) begin
          state_nxt = ST_RF_CNT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_RF_RA;
        end
      end
      ST_RF_CNT: begin
        cnt_nxt   = cnt_r + spin_r;
        g_nxt     = 2'd0;
        state_nxt = ST_GA;
      end
      ST_GA: begin
        sum_nxt   = sum_r + cnt_r;
        xor_nxt   = xor_r ^ cnt_r;
        state_nxt = ST_GB;
      end
      ST_GB: begin
        m_nxt[g_r] = mg + rotl32(sum_r, 9);
        e_nxt      = 3'd0;
        state_nxt  = ST_EL_RD;
      end
      ST_EL_RD: begin
        state_nxt = ST_EL_CMP;
      end
      ST_EL_CMP: begin
        grp_nxt[e_r] = elem;
        state_nxt    = ST_EL_ACC;
      end
      ST_EL_ACC: begin
        m_nxt[g_r] = mg + grp_r[e_r];
        if (e_r == 3'd4) begin
          state_nxt = ST_FIX;
        end else begin
          e_nxt     = e_r + 3'd1;
          state_nxt = ST_EL_RD;
        end
      end
      ST_FIX: begin
        if (grp_r[4] == grp_r[3] && grp_r[2] == grp_r[1]) begin
          grp_nxt[4] = grp_r[4] + (mg ^ FIX_K4);
          grp_nxt[3] = grp_r[3] + (mg ^ FIX_K3);
          grp_nxt[2] = grp_r[2] + ((mg ^ FIX_K2) | {31'd0, mg[0]});
          grp_nxt[1] = grp_r[1] + (mg ^ FIX_K1);
          grp_nxt[0] = grp_r[0] + mg;
        end
        e_nxt     = 3'd0;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        we = 1'b1;
        if (e_r == 3'd4) begin
          if (g_r == 2'd3) begin
            state_nxt = ST_TAIL;
          end else begin
            g_nxt     = g_r + 2'd1;
            state_nxt = ST_GA;
          end
        end else begin
          e_nxt = e_r + 3'd1;
        end
      end
      ST_TAIL: begin
        sum_nxt = (sum_r + rotl32(m_r[0], 23)) ^ m_r[1];
        xor_nxt = (xor_r + rotl32(m_r[2], 13)) ^ m_r[3];
        rp_nxt  = 5'd0;
        if (rfl_r == 2'd2) begin
          rfl_nxt   = 2'd1;
          k_nxt     = 2'd0;
          state_nxt = ST_RF_RA;
        end else begin
          state_nxt = ST_DR_RD;
        end
      end
      ST_DR_RD: begin
        state_nxt = ST_DR_OUT;
      end
      ST_DR_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = rd_r;
          rp_nxt    = rp_r + 5'd1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      pool_mem[waddr] <= wdata;
    end
    rd_r <= pvalid_r[raddr] ? pool_mem[raddr] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      spin_r   <= SPIN_RESET;
      cnt_r    <= 32'd0;
      sum_r    <= 32'd0;
      xor_r    <= 32'd0;
      rp_r     <= 5'(POOL_WORDS);
      primed_r <= 1'b0;
      rfl_r    <= 2'd0;
      ov_r     <= 1'b0;
      pvalid_r <= '0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) begin
        spin_r <= cfg_wdata;
      end
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      xor_r    <= xor_nxt;
      rp_r     <= rp_nxt;
      primed_r <= primed_nxt;
      rfl_r    <= rfl_nxt;
      ov_r     <= ov_nxt;
      if (we) begin
        pvalid_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    g_r    <= g_nxt;
    e_r    <= e_nxt;
    m_r    <= m_nxt;
    grp_r  <= grp_nxt;
    st_r   <= st_nxt;
    mula_r <= mula_nxt;
    acc_r  <= acc_nxt;
    ph_r   <= ph_nxt;
    csel_r <= csel_nxt;
    idx_r  <= idx_nxt;
    od_r   <= od_nxt;
  end

endmodule

>>> sv/brrg_checker.sv
// Port-level checker for the block-refill random generator, bound to the top level.
`timescale 1ns / 1ps
module brrg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [0:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after an accepted item");

  a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !$rose(out_tvalid))
    else $error("seed item produced a value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output changed");

endmodule

bind block_refill_random_generator_core brrg_checker u_brrg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> test/block_refill_random_generator_core_tb.sv
// Self-checking testbench for the block-refill random generator core.
`timescale 1ns / 1ps
module block_refill_random_generator_core_tb;
  import brrg_pkg::*;

  localparam int unsigned WORDS = 20;
  localparam longint unsigned CYCLE_LIMIT = 64'd3000000;
  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_SEED = 1'b1;

  class rng_scoreboard;
    logic [31:0] pool_w [WORDS];
    logic [31:0] ctr_w, sum_w, xor_w, spin;
    int unsigned rd_pos;
    bit primed;
    logic [31:0] pending_values[$];
    int errors;

    function void clear();
      foreach (pool_w[i]) pool_w[i] = '0;
      ctr_w = '0; sum_w = '0; xor_w = '0;
      rd_pos = WORDS; primed = 0; spin = 32'h9E37_79B9;
      errors = 0;
    endfunction

    function logic [31:0] rot(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function logic [31:0] mix64(ref logic [63:0] st);
      logic [63:0] z;
      z = st;
      z = (z ^ (z >> 33)) * 64'hFF51_AFD7_ED55_8CCD;
      z = (z ^ (z >> 33)) * 64'hC4CE_B9FE_1A85_EC53;
      z = z ^ (z >> 33);
      st = z + 64'h9E37_79B9_7F4A_7C15;
      return z[63:32];
    endfunction

    function void block_mix();
      logic [31:0] m [4];
      int unsigned b, p;
      b = ctr_w[3:0];
      m[0] = pool_w[b];
      m[1] = pool_w[(b + 3) & 15];
      m[2] = pool_w[(b + 6) & 15];
      m[3] = pool_w[(b + 9) & 15];
      ctr_w = ctr_w + spin;
      p = 0;
      for (int g = 0; g < 4; g++) begin
        sum_w = sum_w + ctr_w;
        xor_w = xor_w ^ ctr_w;
        m[g] = m[g] + rot(sum_w, 9);
        for (int e = 0; e < 5; e++) begin
          pool_w[p] = (pool_w[p] + rot(m[g], 25)) ^ xor_w;
          m[g] = m[g] + pool_w[p];
          p++;
        end
        if (pool_w[p-1] == pool_w[p-2] && pool_w[p-3] == pool_w[p-4]) begin
          pool_w[p-1] += m[g] ^ 32'd81016;
          pool_w[p-2] += m[g] ^ 32'd297442265;
          pool_w[p-3] += (m[g] ^ 32'd5480) | (m[g] & 32'd1);
          pool_w[p-4] += m[g] ^ 32'd19006808;
          pool_w[p-5] += m[g];
        end
      end
      sum_w = (sum_w + rot(m[0], 23)) ^ m[1];
      xor_w = (xor_w + rot(m[2], 13)) ^ m[3];
      rd_pos = 0;
    endfunction

    function void note_input(logic act, logic [63:0] lo, logic [63:0] hi);
      logic [63:0] st;
      if (act == ACT_SEED) begin
        st = lo ^ (hi << 1) ^ 64'h9E37_79B9_7F4A_7C15;
        for (int i = 0; i < WORDS; i++) pool_w[i] = mix64(st);
        ctr_w = mix64(st); sum_w = mix64(st); xor_w = mix64(st);
        rd_pos = WORDS; primed = 0;
      end else begin
        if (!primed) begin
          block_mix(); primed = 1; rd_pos = WORDS;
        end
        if (rd_pos >= WORDS) block_mix();
        pending_values.push_back(pool_w[rd_pos]);
        rd_pos++;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [31:0] v);
      logic [31:0] e;
      if (pending_values.size() == 0) report($sformatf("unexpected value %h", v));
      else begin
        e = pending_values.pop_front();
        if (v !== e) report($sformatf("value %h, expected %h", v, e));
      end
    endtask
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_we;
  logic [0:0] in_tuser;
  logic [127:0] in_tdata;
  logic [31:0] out_tdata, cfg_wdata;

  rng_scoreboard sb;
  longint unsigned cycles;
  int hold_cycles;
  bit done_flag;

  block_refill_random_generator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    sb = new();
    sb.clear();
    rst_n = 0; in_tvalid = 0; in_tuser = '0; in_tdata = '0;
    out_tready = 0; cfg_we = 0; cfg_wdata = '0;
    hold_cycles = 0; done_flag = 0;
  end

  always @(posedge clk) begin
    cycles <= (rst_n ? cycles + 1 : 0);
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver with random stalls and forced hold-off
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata);
    end
  end

  task send_item(logic act, logic [63:0] lo, logic [63:0] hi, bit gaps);
    int w;
    w = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : 0;
    if (w > 0) begin
      in_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= act;
    in_tdata <= {hi, lo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(act, lo, hi);
  endtask

  task drain();
    in_tvalid <= 0;
    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task write_spin(logic [31:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.spin = v;
  endtask

  function logic [63:0] rnd64();
    logic [63:0] r;
    case ($urandom_range(0, 5))
      0: r = '0;
      1: r = '1;
      default: r = {$urandom(), $urandom()};
    endcase
    return r;
  endfunction

  initial begin
    logic [31:0] spins [5];
    spins = '{32'h9E37_79B9, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h6A09_E667};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: unseeded draws, extreme seeds
    for (int i = 0; i < 3; i++) send_item(ACT_DRAW, '0, '0, 0);
    send_item(ACT_SEED, '0, '0, 0);
    send_item(ACT_DRAW, '1, '1, 0);
    send_item(ACT_SEED, '1, '1, 0);
    for (int i = 0; i < 19; i++) send_item(ACT_DRAW, '0, '0, 0);
    drain();
    // long receiver hold-off while inputs keep coming
    hold_cycles = 600;
    for (int i = 0; i < 30; i++) send_item(ACT_DRAW, rnd64(), rnd64(), 0);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_spin(ph == 4 ? $urandom() : spins[ph]);
      for (int i = 0; i < 180; i++) begin
        if ($urandom_range(0, 24) == 0)
          send_item(ACT_SEED, rnd64(), rnd64(), 1);
        else if ($urandom_range(0, 60) == 0)
          drain();
        else
          send_item(ACT_DRAW, rnd64(), rnd64(), 1);
      end
      drain();
    end
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

>>> sim.f
sv/brrg_pkg.sv
sv/block_refill_random_generator_core.sv
sv/brrg_checker.sv
test/block_refill_random_generator_core_tb.sv
